// File: hdl/mal_pkg.sv
// ----------------------------------------------------------------------------
// mal_pkg
// Shared types, character codes and character class helpers for the mail
// address list lexer.
// ----------------------------------------------------------------------------
package mal_pkg;

	// default ceiling of the comment nesting counter
	localparam int unsigned MAX_COMMENT_DEPTH_DEF = 255;

	// characters that steer the lexer
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LANGLE = 8'h3C;
	localparam logic [7:0] CH_RANGLE = 8'h3E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;

	// one input item
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} mal_in_t;

	// one result item
	typedef struct packed {
		logic [7:0] ch_out;
		logic       forwarded;
		logic       in_quotes;
		logic       is_escaped;
		logic [7:0] depth;
		logic       keep_decommented;
		logic       keep_despaced;
		logic       field_separator;
		logic       entry_end;
		logic       group_open;
		logic       group_found;
		logic       last_out;
	} mal_out_t;

	// single-bit lexer state (the comment level is kept apart, its width
	// follows the depth ceiling)
	typedef struct packed {
		logic escape_pending;
		logic quote_state;
		logic angle_open;
		logic group_state;
		logic colon_seen;
		logic semicolon_seen;
		logic entry_nonblank;
	} mal_flags_t;

	// Latin-1 whitespace: HT..CR, space, NEL, NBSP
	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) || (c == 8'h85) || (c == 8'hA0);
	endfunction

	// Latin-1 printable: space..tilde and NBSP upwards
	function automatic logic is_print(input logic [7:0] c);
		return (c >= 8'h20 && c <= 8'h7E) || (c >= 8'hA0);
	endfunction

endpackage

// File: hdl/mal_step.sv
// ----------------------------------------------------------------------------
// mal_step
// Per-byte update of the lexer: escape, quote and comment tracking, the two
// text filters, separator and entry detection, angle and group nesting.
// ----------------------------------------------------------------------------
module mal_step import mal_pkg::*; #(
	parameter int unsigned MAX_COMMENT_DEPTH = MAX_COMMENT_DEPTH_DEF,
	parameter int unsigned LVL_W             = $clog2(MAX_COMMENT_DEPTH + 1)
) (
	input  mal_in_t          item,
	input  mal_flags_t       flags,
	input  logic [LVL_W-1:0] level,
	input  logic             polarity,
	output mal_out_t         res,
	output mal_flags_t       flags_nxt,
	output logic [LVL_W-1:0] level_nxt
);

	localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_COMMENT_DEPTH);

	logic [7:0]       c;
	logic             sp;
	logic             esc;
	logic             q;
	logic             opened;
	logic             top;
	logic             eend;
	logic [LVL_W-1:0] lvl;
	logic [LVL_W-1:0] d;
	logic [LVL_W+7:0] d_ext;
	mal_flags_t       f;

	assign c  = item.ch;
	assign sp = is_space(c);

	// low byte of the depth as seen by the processors
	assign d_ext = {8'b0, d};

	always_comb begin
		f      = flags;
		lvl    = level;
		esc    = 1'b0;
		q      = flags.quote_state;
		d      = level;
		opened = 1'b0;
		top    = 1'b0;
		eend   = 1'b0;
		res    = '0;

		if (!flags.escape_pending && c == CH_BSLASH) begin
			// escape opener: swallowed, state held
			f.escape_pending = 1'b1;
			res.forwarded    = 1'b0;
		end else begin
			res.forwarded = 1'b1;
			esc           = flags.escape_pending;

			// opening paren and opening quote take effect at once
			if (c == CH_LPAREN && !esc && !flags.quote_state) begin
				if (level < MAX_LVL)
					lvl = level + LVL_W'(1);
			end else if (!flags.quote_state && c == CH_DQUOTE && !esc) begin
				f.quote_state = 1'b1;
				opened        = 1'b1;
			end
			q   = f.quote_state;
			d   = lvl;
			top = (lvl == '0) && !esc;

			// comment and whitespace filters
			res.keep_decommented = (lvl == '0) && (q || (is_print(c) == polarity));
			res.keep_despaced    = !sp || q || esc || (lvl != '0);

			// separator, angle and group nesting
			if (c == CH_COMMA && !flags.group_state && !q && top) begin
				res.field_separator = 1'b1;
				eend                = flags.entry_nonblank;
				f.entry_nonblank    = 1'b0;
			end else begin
				if (!sp)
					f.entry_nonblank = 1'b1;
				if (c == CH_LANGLE && !flags.angle_open && !q && top)
					f.angle_open = 1'b1;
				else if (c == CH_RANGLE && flags.angle_open && !q && top)
					f.angle_open = 1'b0;
				else if (c == CH_COLON && !flags.group_state && !flags.angle_open && top)
					f.group_state = 1'b1;
				else if (c == CH_SEMI && flags.group_state && !flags.angle_open && top)
					f.group_state = 1'b0;
			end

			// group specifier detector, quote aware
			if (c == CH_COLON && !flags.colon_seen && !q && top)
				f.colon_seen = 1'b1;
			else if (c == CH_SEMI && !flags.semicolon_seen && flags.colon_seen && !q && top)
				f.semicolon_seen = 1'b1;

			// closing paren and closing quote take effect after the byte
			if (c == CH_RPAREN && !esc && !f.quote_state && lvl != '0)
				lvl = lvl - LVL_W'(1);
			else if (f.quote_state && c == CH_DQUOTE && !opened && !esc)
				f.quote_state = 1'b0;

			f.escape_pending = 1'b0;
		end

		res.ch_out      = c;
		res.in_quotes   = q;
		res.is_escaped  = esc;
		res.depth       = d_ext[7:0];
		res.entry_end   = eend;
		res.group_open  = f.group_state;
		res.group_found = f.semicolon_seen;
		res.last_out    = item.last;

		// end of string: close the pending entry and start afresh
		if (item.last) begin
			if (f.entry_nonblank)
				res.entry_end = 1'b1;
			f   = '0;
			lvl = '0;
		end
	end

	assign flags_nxt = f;
	assign level_nxt = lvl;

endmodule

// File: hdl/mail_address_list_lexer.sv
// ----------------------------------------------------------------------------
// mail_address_list_lexer
// Tokenizer for a mail address list header. Takes one Latin-1 byte per
// transfer and returns exactly one result per byte, in order: the byte, its
// quote, escape and comment state, keep flags for comment-removed and
// whitespace-removed text, top-level comma and entry-end marks, and group
// nesting and detection. A new byte is taken every cycle unless the output is
// stalled; each byte passes an input register and then a result register
// before its result is offered. All lexer state returns to reset after the
// byte marked last; the polarity register is kept.
// ----------------------------------------------------------------------------
module mail_address_list_lexer import mal_pkg::*; #(
	parameter int unsigned MAX_COMMENT_DEPTH = MAX_COMMENT_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	// byte stream
	input  logic     src_valid,
	output logic     src_stall,
	input  mal_in_t  src_item,
	// results
	output logic     res_valid,
	input  logic     res_stall,
	output mal_out_t res_item,
	// polarity register write
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  logic     cfg_data
);

	localparam int unsigned LVL_W = $clog2(MAX_COMMENT_DEPTH + 1);

	logic             valid_s1;
	mal_in_t          item_s1;
	logic             out_free;
	logic             adv;
	logic             polarity_q;
	mal_flags_t       flags_q;
	mal_flags_t       flags_nxt;
	logic [LVL_W-1:0] level_q;
	logic [LVL_W-1:0] level_nxt;
	mal_out_t         res_nxt;

	// handshake: result register free or being drained
	assign out_free  = !res_valid || !res_stall;
	assign adv       = valid_s1 && out_free;
	assign src_stall = valid_s1 && !out_free;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall)
			item_s1 <= src_item;
	end

	// per-byte update
	mal_step #(
		.MAX_COMMENT_DEPTH(MAX_COMMENT_DEPTH),
		.LVL_W            (LVL_W)
	) u_step (
		.item     (item_s1),
		.flags    (flags_q),
		.level    (level_q),
		.polarity (polarity_q),
		.res      (res_nxt),
		.flags_nxt(flags_nxt),
		.level_nxt(level_nxt)
	);

	// lexer state, updated once per byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			level_q <= '0;
		end else if (adv) begin
			flags_q <= flags_nxt;
			level_q <= level_nxt;
		end
	end

	// polarity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			polarity_q <= cfg_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_free) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_item <= res_nxt;
	end

	// checks
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item_s1.last) |=> (flags_q == '0 && level_q == '0))
		else $error("lexer state not cleared after last byte");

	a_sep_top: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.field_separator) |->
		(res_item.depth == 8'd0 && !res_item.in_quotes && !res_item.is_escaped))
		else $error("separator flagged inside quotes, comment or escape");

	a_swallow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_item.forwarded) |->
		(!res_item.keep_despaced && !res_item.keep_decommented && !res_item.field_separator))
		else $error("escape opener marked as kept");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (valid_s1 && res_valid))
		else $error("input stalled with a free stage");

endmodule
